/* hdl/scf_pkg.sv */
`default_nettype none

package scf_pkg;

    localparam int CNT_W  = 7;
    localparam int STEP_W = 5;

    localparam logic [CNT_W-1:0] CNT_SAT = 7'd127;

    localparam logic [7:0] SYNC0   = 8'hF8;
    localparam logic [7:0] SYNC1   = 8'h7D;
    localparam logic [7:0] HDR_TAG = 8'h2E;

    localparam logic [15:0] TIMER_SAT = 16'hFFFF;

    localparam logic [1:0] FN_PAYLOAD = 2'd0;
    localparam logic [1:0] FN_ACK     = 2'd1;
    localparam logic [1:0] FN_TICK    = 2'd2;

    localparam logic CFG_ACK_CODE = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam logic [15:0] TIMEOUT_RST = 16'd200;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       last;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_BYTE    = 3'd0,
        ST_ACK_OK  = 3'd1,
        ST_ACK_BAD = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_REJECT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        A_NONE,
        A_LOAD,
        A_IDX_CLR,
        A_IDX_INC,
        A_FINISH,
        A_CLR_LOADER,
        A_CLR_WAIT,
        A_TICK
    } act_t;

    typedef enum logic [3:0] {
        E_ZERO,
        E_SYNC0,
        E_SYNC1,
        E_LEN,
        E_TAG,
        E_RAM,
        E_C1,
        E_C2,
        E_DATA
    } emit_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NSTART,
        C_PAY,
        C_ACK,
        C_TICK,
        C_NLAST,
        C_OVL,
        C_MORE,
        C_NTIMEOUT
    } cond_t;

    typedef struct packed {
        act_t    act;
        emit_t   emit;
        logic    strobe;
        logic    last;
        status_t status;
        cond_t   cond;
        step_t   target;
    } ucode_t;

    typedef struct packed {
        logic pay;
        logic ack;
        logic tick;
        logic nlast;
        logic ovl;
        logic more;
        logic ntimeout;
    } dp_flags_t;

    localparam step_t P_IDLE  = 5'd0;
    localparam step_t P_TPAY  = 5'd1;
    localparam step_t P_TACK  = 5'd2;
    localparam step_t P_TTICK = 5'd3;
    localparam step_t P_IGN   = 5'd4;
    localparam step_t P_LOAD  = 5'd5;
    localparam step_t P_TOVL  = 5'd6;
    localparam step_t P_SYNC0 = 5'd7;
    localparam step_t P_SYNC1 = 5'd8;
    localparam step_t P_LEN   = 5'd9;
    localparam step_t P_TAG   = 5'd10;
    localparam step_t P_PAY   = 5'd11;
    localparam step_t P_C1    = 5'd12;
    localparam step_t P_C2    = 5'd13;
    localparam step_t P_REJ   = 5'd14;
    localparam step_t P_ACK   = 5'd15;
    localparam step_t P_TICK  = 5'd16;
    localparam step_t P_TCHK  = 5'd17;
    localparam step_t P_TOUT  = 5'd18;
    localparam step_t P_LAST  = P_TOUT;

    function automatic ucode_t uw(act_t a, emit_t e, logic s, logic l, status_t st,
                                  cond_t c, step_t t);
        ucode_t w;
        w.act    = a;
        w.emit   = e;
        w.strobe = s;
        w.last   = l;
        w.status = st;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic ucode_t scf_rom(step_t s);
        ucode_t w;
        case (s)
            P_IDLE:  w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_NSTART, P_IDLE);
            P_TPAY:  w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_PAY, P_LOAD);
            P_TACK:  w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_ACK, P_ACK);
            P_TTICK: w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_TICK, P_TICK);
            P_IGN:   w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_ALWAYS, P_IDLE);
            P_LOAD:  w = uw(A_LOAD, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_NLAST, P_IDLE);
            P_TOVL:  w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_OVL, P_REJ);
            P_SYNC0: w = uw(A_NONE, E_SYNC0, 1'b1, 1'b0, ST_BYTE, C_NEVER, P_IDLE);
            P_SYNC1: w = uw(A_NONE, E_SYNC1, 1'b1, 1'b0, ST_BYTE, C_NEVER, P_IDLE);
            P_LEN:   w = uw(A_NONE, E_LEN, 1'b1, 1'b0, ST_BYTE, C_NEVER, P_IDLE);
            P_TAG:   w = uw(A_IDX_CLR, E_TAG, 1'b1, 1'b0, ST_BYTE, C_NEVER, P_IDLE);
            P_PAY:   w = uw(A_IDX_INC, E_RAM, 1'b1, 1'b0, ST_BYTE, C_MORE, P_PAY);
            P_C1:    w = uw(A_NONE, E_C1, 1'b1, 1'b0, ST_BYTE, C_NEVER, P_IDLE);
            P_C2:    w = uw(A_FINISH, E_C2, 1'b1, 1'b1, ST_BYTE, C_ALWAYS, P_IDLE);
            P_REJ:   w = uw(A_CLR_LOADER, E_ZERO, 1'b1, 1'b0, ST_REJECT, C_ALWAYS, P_IDLE);
            P_ACK:   w = uw(A_CLR_WAIT, E_DATA, 1'b1, 1'b0, ST_ACK_OK, C_ALWAYS, P_IDLE);
            P_TICK:  w = uw(A_TICK, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_NEVER, P_IDLE);
            P_TCHK:  w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_NTIMEOUT, P_IDLE);
            P_TOUT:  w = uw(A_CLR_WAIT, E_ZERO, 1'b1, 1'b0, ST_TIMEOUT, C_ALWAYS, P_IDLE);
            default: w = uw(A_NONE, E_ZERO, 1'b0, 1'b0, ST_BYTE, C_ALWAYS, P_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/scf_ram.sv */
`default_nettype none

module scf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/scf_seq.sv */
`default_nettype none

module scf_seq
    import scf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire dp_flags_t flags,
    output logic           busy,
    output ucode_t         ctl
);

    step_t step_reg;
    step_t step_next;
    logic  take;

    assign ctl  = scf_rom(step_reg);
    assign busy = (step_reg != P_IDLE);

    always_comb
    begin
        case (ctl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NSTART:   take = !start;
            C_PAY:      take = flags.pay;
            C_ACK:      take = flags.ack;
            C_TICK:     take = flags.tick;
            C_NLAST:    take = flags.nlast;
            C_OVL:      take = flags.ovl;
            C_MORE:     take = flags.more;
            C_NTIMEOUT: take = flags.ntimeout;
            default:    take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            step_next = ctl.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= P_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= P_LAST)
        else $error("step counter left the program");
`endif

endmodule

`default_nettype wire

/* hdl/scf_dp.sv */
`default_nettype none

module scf_dp
    import scf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire req_t        req,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire ucode_t      ctl,
    output dp_flags_t        flags,
    output logic             rsp_strobe,
    output rsp_t             rsp
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

    req_t             item_reg;
    logic [7:0]       ack_code_reg;
    logic [15:0]      timeout_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             ovl_reg;
    logic             ovl_next;
    logic             wait_reg;
    logic             wait_next;
    logic [15:0]      timer_reg;
    logic [15:0]      timer_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             strobe_reg;

    logic             room;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;
    logic [7:0]       c1;
    logic [7:0]       c2;
    logic [7:0]       len_byte;

    assign room = (count_reg < MAX_CNT);
    assign ram_we = (ctl.act == A_LOAD) && room;
    assign ram_raddr = (idx_next < MAX_CNT) ? idx_next[AW-1:0] : '0;

    scf_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(item_reg.data_byte),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign len_byte = {1'b0, count_reg} + 8'd2;
    assign c1 = ~sum_reg;
    assign c2 = len_byte + HDR_TAG + sum_reg + c1;

    always_comb
    begin
        flags.pay      = (item_reg.func == FN_PAYLOAD) && !wait_reg;
        flags.ack      = (item_reg.func == FN_ACK) && wait_reg;
        flags.tick     = (item_reg.func == FN_TICK) && wait_reg;
        flags.nlast    = !item_reg.last;
        flags.ovl      = ovl_reg;
        flags.more     = ({1'b0, idx_reg} + 8'd1) < {1'b0, count_reg};
        flags.ntimeout = (timer_reg < timeout_reg);
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        ovl_next   = ovl_reg;
        wait_next  = wait_reg;
        timer_next = timer_reg;
        idx_next   = idx_reg;
        case (ctl.act)
            A_NONE:
            begin
            end
            A_LOAD:
            begin
                if (room)
                begin
                    sum_next = sum_reg + item_reg.data_byte;
                end
                else
                begin
                    ovl_next = 1'b1;
                end
                if (count_reg < CNT_SAT)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            A_IDX_CLR:
            begin
                idx_next = '0;
            end
            A_IDX_INC:
            begin
                idx_next = idx_reg + 1'b1;
            end
            A_FINISH:
            begin
                count_next = '0;
                sum_next   = '0;
                ovl_next   = 1'b0;
                wait_next  = 1'b1;
                timer_next = '0;
            end
            A_CLR_LOADER:
            begin
                count_next = '0;
                sum_next   = '0;
                ovl_next   = 1'b0;
            end
            A_CLR_WAIT:
            begin
                wait_next  = 1'b0;
                timer_next = '0;
            end
            A_TICK:
            begin
                if (timer_reg < TIMER_SAT)
                begin
                    timer_next = timer_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_next.out_last = ctl.last;
        rsp_next.status   = ctl.status;
        if ((ctl.status == ST_ACK_OK) && (item_reg.data_byte != ack_code_reg))
        begin
            rsp_next.status = ST_ACK_BAD;
        end
        case (ctl.emit)
            E_ZERO:  rsp_next.out_byte = 8'd0;
            E_SYNC0: rsp_next.out_byte = SYNC0;
            E_SYNC1: rsp_next.out_byte = SYNC1;
            E_LEN:   rsp_next.out_byte = len_byte;
            E_TAG:   rsp_next.out_byte = HDR_TAG;
            E_RAM:   rsp_next.out_byte = ram_rdata;
            E_C1:    rsp_next.out_byte = c1;
            E_C2:    rsp_next.out_byte = c2;
            E_DATA:  rsp_next.out_byte = item_reg.data_byte;
            default: rsp_next.out_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_code_reg <= 8'd0;
            timeout_reg  <= TIMEOUT_RST;
            count_reg    <= '0;
            sum_reg      <= '0;
            ovl_reg      <= 1'b0;
            wait_reg     <= 1'b0;
            timer_reg    <= '0;
            idx_reg      <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == CFG_ACK_CODE))
            begin
                ack_code_reg <= cfg_wdata[7:0];
            end
            if (cfg_we && (cfg_addr == CFG_TIMEOUT))
            begin
                timeout_reg <= cfg_wdata;
            end
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            ovl_reg    <= ovl_next;
            wait_reg   <= wait_next;
            timer_reg  <= timer_next;
            idx_reg    <= idx_next;
            strobe_reg <= ctl.strobe;
        end
    end

    assign rsp_strobe = strobe_reg;
    assign rsp        = rsp_reg;

`ifndef SYNTHESIS
    a_last_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rsp_reg.out_last) |-> wait_reg)
        else $error("frame ended without arming the acknowledge wait");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !ovl_reg |-> (count_reg <= MAX_CNT))
        else $error("payload count passed the store depth without overflow mark");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit == E_RAM) |-> (idx_reg < count_reg))
        else $error("payload read past the loaded length");
`endif

endmodule

`default_nettype wire

/* hdl/serial_command_framer_with_ack.sv */
// Serial command framer with acknowledge.
// A request is taken at a rising edge where start is high and busy is low.
// A request carries func, data_byte and last: payload bytes are stored until
// one is marked last, acknowledge requests close the wait that follows a
// frame and tick requests close it when it times out. After the taking edge
// busy stays high until the sequencer has handled the request; the next
// request can be taken at the edge that ends the first cycle with busy low.
// A last byte starts a frame of L+6 bytes, one per cycle on rsp with
// rsp_strobe, that ends with out_last set; busy stays high while the frame
// bytes are produced. The control program runs one step per cycle and every
// result is registered once before it reaches rsp.
// Status results (ack ok, wrong ack, timeout, rejected) appear on rsp with
// out_last low.
// Every result stands on rsp for exactly one cycle; the receiver cannot
// stall the block and must take each result when rsp_strobe is high.
// The user writes ack_code (index 0) and timeout_ticks (index 1) via cfg_we,
// cfg_addr, cfg_wdata only while the block is idle, unchecked by the block.
// Reset sets them to 0 and 200, clears the loader and the acknowledge wait.
`default_nettype none

module serial_command_framer_with_ack
    import scf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        req,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output logic             rsp_strobe,
    output rsp_t             rsp
);

    ucode_t    ctl;
    dp_flags_t flags;
    logic      accept;

    assign accept = start && !busy;

    scf_seq u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .flags(flags),
        .busy (busy),
        .ctl  (ctl)
    );

    scf_dp #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .flags     (flags),
        .rsp_strobe(rsp_strobe),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* sim/framer_check_pkg.sv */
package framer_check_pkg;

    import scf_pkg::*;

    class framer_scoreboard;
        int unsigned depth;
        logic [7:0]  ack_value;
        logic [15:0] timeout_limit;
        logic [7:0]  payload_mem [64];
        logic [6:0]  load_count;
        logic [7:0]  load_sum;
        bit          too_long;
        bit          awaiting_ack;
        logic [15:0] ticks_waited;
        rsp_t        expected_rsp [$];
        int          errors;

        function new(int unsigned max_payload);
            depth = max_payload;
            ack_value = 8'h00;
            timeout_limit = TIMEOUT_RST;
            awaiting_ack = 1'b0;
            ticks_waited = '0;
            errors = 0;
            clear_loader();
        endfunction

        function void clear_loader();
            load_count = '0;
            load_sum = '0;
            too_long = 1'b0;
        endfunction

        function void queue_rsp(logic [7:0] value, logic fin, status_t st);
            rsp_t r;
            r.out_byte = value;
            r.out_last = fin;
            r.status = st;
            expected_rsp.push_back(r);
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void set_reg(logic addr, logic [15:0] value);
            if (addr == CFG_ACK_CODE)
                ack_value = value[7:0];
            else
                timeout_limit = value;
        endfunction

        // Returns 1 when the request changes the state of the block.
        function bit note_request(req_t item);
            logic [7:0] len_byte;
            logic [7:0] c1;
            logic [7:0] c2;
            case (item.func)
                FN_PAYLOAD: begin
                    if (awaiting_ack)
                        return 1'b0;
                    if (load_count < depth) begin
                        payload_mem[load_count] = item.data_byte;
                        load_sum = load_sum + item.data_byte;
                    end else begin
                        too_long = 1'b1;
                    end
                    if (load_count != CNT_SAT)
                        load_count++;
                    if (!item.last)
                        return 1'b1;
                    if (too_long) begin
                        queue_rsp(8'h00, 1'b0, ST_REJECT);
                        clear_loader();
                        return 1'b1;
                    end
                    len_byte = {1'b0, load_count} + 8'd2;
                    c1 = ~load_sum;
                    c2 = len_byte + HDR_TAG + load_sum + c1;
                    queue_rsp(SYNC0, 1'b0, ST_BYTE);
                    queue_rsp(SYNC1, 1'b0, ST_BYTE);
                    queue_rsp(len_byte, 1'b0, ST_BYTE);
                    queue_rsp(HDR_TAG, 1'b0, ST_BYTE);
                    for (int i = 0; i < load_count; i++)
                        queue_rsp(payload_mem[i], 1'b0, ST_BYTE);
                    queue_rsp(c1, 1'b0, ST_BYTE);
                    queue_rsp(c2, 1'b1, ST_BYTE);
                    clear_loader();
                    awaiting_ack = 1'b1;
                    ticks_waited = '0;
                    return 1'b1;
                end
                FN_ACK: begin
                    if (!awaiting_ack)
                        return 1'b0;
                    awaiting_ack = 1'b0;
                    ticks_waited = '0;
                    queue_rsp(item.data_byte, 1'b0,
                              item.data_byte == ack_value ? ST_ACK_OK : ST_ACK_BAD);
                    return 1'b1;
                end
                FN_TICK: begin
                    if (!awaiting_ack)
                        return 1'b0;
                    if (ticks_waited != TIMER_SAT)
                        ticks_waited++;
                    if (ticks_waited >= timeout_limit) begin
                        awaiting_ack = 1'b0;
                        ticks_waited = '0;
                        queue_rsp(8'h00, 1'b0, ST_TIMEOUT);
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void check_rsp(rsp_t got, time stamp);
            rsp_t want;
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result byte %02h last %0b status %0d",
                         stamp, got.out_byte, got.out_last, got.status);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte expected %02h actual %02h",
                         stamp, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.out_last !== want.out_last) begin
                $display("%0t: out_last expected %0b actual %0b",
                         stamp, want.out_last, got.out_last);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         stamp, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

endpackage

/* sim/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import scf_pkg::*;
    import framer_check_pkg::*;

    localparam int          PAYLOAD_MAX = 32;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  FN_UNUSED   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    req_t        req_in = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        rsp_strobe;
    rsp_t        rsp_out;

    framer_scoreboard board = new(PAYLOAD_MAX);
    int unsigned      useful_items = 0;
    int unsigned      cycle_count = 0;
    bit               steady = 1'b0;

    serial_command_framer_with_ack #(
        .MAX_PAYLOAD(PAYLOAD_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req_in),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rsp_strobe(rsp_strobe),
        .rsp       (rsp_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_strobe === 1'b1)
            board.check_rsp(rsp_out, $time);
    end

    function automatic int unsigned idle_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic send(input logic [1:0] fn, input logic [7:0] value, input logic fin,
                        input int unsigned gap);
        req_t item;
        item.func = fn;
        item.data_byte = value;
        item.last = fin;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_in <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (board.note_request(item))
            useful_items++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Closes any open command and acknowledge wait, then lets the block go quiet.
    task automatic settle();
        if (board.load_count != 0)
            send(FN_PAYLOAD, 8'($urandom), 1'b1, idle_gap());
        if (board.awaiting_ack)
            send(FN_ACK, board.ack_value, 1'($urandom_range(0, 1)), idle_gap());
        drain();
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] code, input logic [7:0] pad,
                                input logic [15:0] limit);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_ACK_CODE;
        cfg_wdata <= {pad, code};
        @(posedge clk);
        cfg_addr <= CFG_TIMEOUT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(CFG_ACK_CODE, {pad, code});
        board.set_reg(CFG_TIMEOUT, limit);
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned stop_at;
        int unsigned len;
        int unsigned ticks;
        int unsigned pick;
        stop_at = useful_items + budget;
        while (useful_items < stop_at) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 12) begin
                send(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                     idle_gap());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    len = $urandom_range(1, 6);
                else if (pick < 90)
                    len = $urandom_range(7, PAYLOAD_MAX);
                else
                    len = $urandom_range(PAYLOAD_MAX + 1, PAYLOAD_MAX + 8);
                for (int i = 1; i <= len; i++)
                    send(FN_PAYLOAD, 8'($urandom), i == len, idle_gap());
                if ($urandom_range(0, 9) == 0)
                    send(FN_PAYLOAD, 8'($urandom), 1'($urandom_range(0, 1)), idle_gap());
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    ticks = 0;
                else if (board.timeout_limit > 40)
                    ticks = $urandom_range(1, 20);
                else if (pick < 75)
                    ticks = board.timeout_limit + 1;
                else
                    ticks = $urandom_range(0, board.timeout_limit);
                for (int i = 0; i < ticks && board.awaiting_ack; i++)
                    send(FN_TICK, 8'($urandom), 1'($urandom_range(0, 1)), idle_gap());
                if (board.awaiting_ack)
                    send(FN_ACK,
                         $urandom_range(0, 99) < 65 ? board.ack_value : 8'($urandom),
                         1'($urandom_range(0, 1)), idle_gap());
            end
            if ($urandom_range(0, 19) == 0)
                drain();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(FN_TICK, 8'h00, 1'b0, 0);
        send(FN_ACK, 8'hFF, 1'b1, 1);
        send(FN_UNUSED, 8'hA5, 1'b1, 0);
        send(FN_PAYLOAD, 8'h00, 1'b1, 2);
        send(FN_ACK, 8'h00, 1'b0, 0);
        for (int i = 0; i < 3; i++)
            send(FN_PAYLOAD, 8'hFF, i == 2, 0);
        send(FN_ACK, 8'h80, 1'b1, 1);
        for (int i = 0; i < PAYLOAD_MAX; i++)
            send(FN_PAYLOAD, i == 0 ? 8'h00 : (i == 1 ? 8'hFF : 8'($urandom)),
                 i == PAYLOAD_MAX - 1, idle_gap());
        send(FN_PAYLOAD, 8'h5A, 1'b1, 0);
        for (int i = 0; i < TIMEOUT_RST; i++)
            send(FN_TICK, 8'($urandom), 1'($urandom_range(0, 1)), idle_gap());
        for (int i = 0; i <= PAYLOAD_MAX; i++)
            send(FN_PAYLOAD, 8'($urandom), i == PAYLOAD_MAX, 0);
        for (int i = 0; i < 130; i++)
            send(FN_PAYLOAD, 8'($urandom), i == 129, 0);
        send(FN_PAYLOAD, 8'h81, 1'b0, 3);
        send(FN_PAYLOAD, 8'h7E, 1'b1, 0);
        send(FN_ACK, 8'h00, 1'b0, 0);
        settle();

        write_config(8'hFF, 8'($urandom), 16'd1);
        send(FN_PAYLOAD, 8'h33, 1'b1, 0);
        send(FN_ACK, 8'hFF, 1'b0, 0);
        run_phase(20);
        settle();

        write_config(8'($urandom), 8'($urandom), 16'd0);
        run_phase(20);
        settle();

        write_config(8'($urandom), 8'($urandom), 16'hFFFF);
        run_phase(15);
        settle();

        write_config(8'h00, 8'h00, 16'($urandom_range(2, 30)));
        run_phase(25);
        settle();
        repeat (10) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/scf_pkg.sv
hdl/scf_ram.sv
hdl/scf_seq.sv
hdl/scf_dp.sv
hdl/serial_command_framer_with_ack.sv
sim/framer_check_pkg.sv
sim/testbench.sv
